### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the lis checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define LIS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lis assertion failed");

// checked on every rising edge, reset included
`define LIS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lis assertion failed");

`endif

### sv/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// types, constants and the control store of the lis length tracker
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned LenOutW  = 11;

  typedef logic [1:0] step_t;

  typedef enum logic [1:0] {
    OP_FETCH,   // wait for an input beat, latch key, set up search bounds
    OP_PROBE,   // read the tail at the midpoint
    OP_NARROW,  // compare tail with key, move one bound
    OP_COMMIT   // replace or append the tail, load the result register
  } op_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_BEAT,
    COND_LO_LT_HI,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jmp;  // taken when the condition holds
    step_t nxt;  // taken otherwise
  } ctrl_t;

  localparam step_t StepFetch  = 2'd0;
  localparam step_t StepProbe  = 2'd1;
  localparam step_t StepNarrow = 2'd2;
  localparam step_t StepCommit = 2'd3;

  function automatic ctrl_t ucode(step_t step);
    ctrl_t c;
    case (step)
      StepFetch:  c = '{op: OP_FETCH,  cond: COND_IN_BEAT,  jmp: StepProbe, nxt: StepFetch};
      StepProbe:  c = '{op: OP_PROBE,  cond: COND_LO_LT_HI, jmp: StepNarrow, nxt: StepCommit};
      StepNarrow: c = '{op: OP_NARROW, cond: COND_ALWAYS,   jmp: StepProbe, nxt: StepProbe};
      StepCommit: c = '{op: OP_COMMIT, cond: COND_OUT_FREE, jmp: StepFetch, nxt: StepCommit};
      default:    c = '{op: OP_FETCH,  cond: COND_ALWAYS,   jmp: StepFetch, nxt: StepFetch};
    endcase
    return c;
  endfunction

endpackage

### sv/lis_length_tracker.sv
// ----------------------------------------------------------------------------
// lis_length_tracker
// longest strictly increasing subsequence length by patience sorting
// ----------------------------------------------------------------------------
// One value per input beat; each beat yields one result beat holding the
// longest strictly increasing subsequence length of the current sequence and a
// sticky overflow flag. tuser on the input starts a new sequence. An item runs a
// fetch step, k binary-search probes, a closing probe step and a commit step,
// where k is at most ceil(log2(length+1)); a full store holds 1024 tails.
// Each probe is a probe step and a narrow step because the tail memory has one
// port with a registered read, and the compare waits for that data. A new beat
// is taken while the previous result still waits on the output register.
module lis_length_tracker #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lis_pkg::InDataW-1:0]      s_axis_tdata,  // [31:0] value
  input  logic [0:0]                       s_axis_tuser,  // [0] first
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lis_pkg::OutDataW-1:0]     m_axis_tdata,  // [10:0] lis_length, rest zero
  output logic [0:0]                       m_axis_tuser   // [0] overflow
);
  import lis_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam logic [VALUE_BITS-1:0] KeySign = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [LW-1:0] MaxLen = LW'(MAX_LEN);

  step_t                 step_q;
  ctrl_t                 ctrl;
  logic                  cond_ok;
  logic [LW-1:0]         lo_q, hi_q, mid_q, length_q;
  logic [LW-1:0]         mid;
  logic [LW-1:0]         len_nxt;
  logic [VALUE_BITS-1:0] key_q, key_d, rdata_q;
  logic [63:0]           raw64;
  logic [31:0]           len32;
  logic                  ovf_q;
  logic                  m_valid_q;
  logic [LenOutW-1:0]    out_len_q;
  logic                  commit_fire, tail_we;

  logic [VALUE_BITS-1:0] tails_mem [MAX_LEN];

  assign ctrl = ucode(step_q);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_IN_BEAT:  cond_ok = s_axis_tvalid;
      COND_LO_LT_HI: cond_ok = (lo_q < hi_q);
      COND_OUT_FREE: cond_ok = !m_valid_q || m_axis_tready;
      default:       cond_ok = 1'b0;
    endcase
  end

  // offset-binary key so unsigned order matches signed order
  assign raw64 = {32'b0, s_axis_tdata};
  assign key_d = raw64[VALUE_BITS-1:0] ^ KeySign;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  assign commit_fire = (ctrl.op == OP_COMMIT) && cond_ok;
  // replace when a tail was found, else append while there is room
  assign tail_we = commit_fire && ((lo_q < length_q) || (length_q < MaxLen));
  assign len_nxt = (lo_q >= length_q && length_q < MaxLen) ? length_q + LW'(1) : length_q;
  assign len32   = 32'(len_nxt);

  assign s_axis_tready = (ctrl.op == OP_FETCH);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW-LenOutW){1'b0}}, out_len_q};
  assign m_axis_tuser  = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StepFetch;
      length_q  <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      key_q     <= '0;
      out_len_q <= '0;
    end else begin
      step_q <= cond_ok ? ctrl.jmp : ctrl.nxt;
      if (m_axis_tready && !commit_fire) begin
        m_valid_q <= 1'b0;
      end
      case (ctrl.op)
        OP_FETCH: begin
          if (cond_ok) begin
            key_q <= key_d;
            lo_q  <= '0;
            if (s_axis_tuser[0]) begin
              length_q <= '0;
              hi_q     <= '0;
            end else begin
              hi_q <= length_q;
            end
          end
        end
        OP_PROBE: begin
          mid_q <= mid;
        end
        OP_NARROW: begin
          if (rdata_q < key_q) begin
            lo_q <= mid_q + LW'(1);
          end else begin
            hi_q <= mid_q;
          end
        end
        OP_COMMIT: begin
          if (commit_fire) begin
            length_q  <= len_nxt;
            out_len_q <= len32[LenOutW-1:0];
            m_valid_q <= 1'b1;
            if (lo_q >= length_q && length_q >= MaxLen) begin
              ovf_q <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tail store: one port, registered read
  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tails_mem[lo_q[AW-1:0]] <= key_q;
    end
    if (ctrl.op == OP_PROBE) begin
      rdata_q <= tails_mem[mid[AW-1:0]];
    end
  end

endmodule

### sv/lis_checker.sv
// ----------------------------------------------------------------------------
// lis_checker
// port-level checks of the lis length tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lis_checker #(
  parameter int unsigned MAX_LEN = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a stalled result beat holds
  `LIS_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // the search always follows an accepted beat, so the next cycle is busy
  `LIS_ASSERT(a_busy_after_beat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // overflow is sticky until reset, a new sequence keeps it
  `LIS_ASSERT(a_ovf_sticky, clk_i, rst_ni, m_axis_tuser[0] |=> m_axis_tuser[0])
  // no result can appear right out of reset
  `LIS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind lis_length_tracker lis_checker #(.MAX_LEN(MAX_LEN)) u_lis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
